[hw/rtl/ccur_pkg.sv]
// ----------------------------------------------------------------------------
// ccur_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package ccur_pkg;

  // Console limits
  localparam int unsigned MAX_COLUMNS = 64;
  localparam int unsigned MAX_ROWS    = 16;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLS_W  = 7;   // column count / cursor column
  localparam int unsigned ROWS_W  = 5;   // row count register
  localparam int unsigned TCOL_W  = 6;   // column of a draw
  localparam int unsigned TROW_W  = 4;   // row of a draw / cursor row

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;
  localparam logic [COLS_W-1:0] COLUMNS_RESET = 7'd15;
  localparam logic [ROWS_W-1:0] ROWS_RESET    = 5'd8;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACK    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // Request kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One job: an optional scroll followed by an optional draw
  typedef struct packed {
    logic              has_scroll;
    logic              has_draw;
    logic [CHAR_W-1:0] glyph;
    logic [TCOL_W-1:0] column;
    logic [TROW_W-1:0] row;
  } job_t;

endpackage

[hw/rtl/ccur_char_if.sv]
// ----------------------------------------------------------------------------
// ccur_char_if
// Character input channel: valid/ready with one character byte.
// ----------------------------------------------------------------------------
interface ccur_char_if;
  logic                         valid;
  logic                         ready;
  logic [ccur_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

[hw/rtl/ccur_req_if.sv]
// ----------------------------------------------------------------------------
// ccur_req_if
// Request output channel: draw or scroll requests, valid/ready.
// ----------------------------------------------------------------------------
interface ccur_req_if;
  logic                         valid;
  logic                         ready;
  logic                         request_kind;
  logic [ccur_pkg::CHAR_W-1:0]  glyph_code;
  logic [ccur_pkg::TCOL_W-1:0]  text_column;
  logic [ccur_pkg::TROW_W-1:0]  text_row;
  logic                         last_of_run;

  modport source (output valid, output request_kind, output glyph_code,
                  output text_column, output text_row, output last_of_run,
                  input ready);
  modport sink   (input valid, input request_kind, input glyph_code,
                  input text_column, input text_row, input last_of_run,
                  output ready);
endinterface

[hw/rtl/ccur_front.sv]
// ----------------------------------------------------------------------------
// ccur_front
// Accepts characters, keeps the cursor and the console size registers, and
// turns each character into a job of up to two requests.
// ----------------------------------------------------------------------------
module ccur_front (
  input  logic                              clk,
  input  logic                              rst,
  ccur_char_if.sink                         chars,
  input  logic                              cfg_we,
  input  logic [ccur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccur_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              job_valid,
  input  logic                              job_ready,
  output ccur_pkg::job_t                    job
);

  logic [ccur_pkg::COLS_W-1:0] columns_in_use;
  logic [ccur_pkg::ROWS_W-1:0] rows_in_use;
  logic [ccur_pkg::COLS_W-1:0] cursor_column, cursor_column_next;
  logic [ccur_pkg::TROW_W-1:0] cursor_row, cursor_row_next;

  logic [ccur_pkg::COLS_W-1:0] cols_eff, col_cap, tab_col, draw_col;
  logic [ccur_pkg::ROWS_W-1:0] rows_eff;
  logic [ccur_pkg::TROW_W-1:0] rows_last, row_cap, nl_row, draw_row;
  logic                        nl_scroll, wrap, accept;

  // Effective console size
  always_comb begin
    cols_eff = columns_in_use;
    if (columns_in_use == '0) cols_eff = ccur_pkg::COLS_W'(1);
    else if (columns_in_use > ccur_pkg::COLS_W'(ccur_pkg::MAX_COLUMNS))
      cols_eff = ccur_pkg::COLS_W'(ccur_pkg::MAX_COLUMNS);
    rows_eff = rows_in_use;
    if (rows_in_use == '0) rows_eff = ccur_pkg::ROWS_W'(1);
    else if (rows_in_use > ccur_pkg::ROWS_W'(ccur_pkg::MAX_ROWS))
      rows_eff = ccur_pkg::ROWS_W'(ccur_pkg::MAX_ROWS);
    rows_last = ccur_pkg::TROW_W'(rows_eff - ccur_pkg::ROWS_W'(1));
  end

  // Cursor held inside a possibly shrunken area
  always_comb begin
    col_cap = (cursor_column > cols_eff) ? cols_eff : cursor_column;
    row_cap = (cursor_row > rows_last) ? rows_last : cursor_row;
  end

  // Newline target and scroll decision
  always_comb begin
    if ({1'b0, row_cap} + ccur_pkg::ROWS_W'(1) >= rows_eff) begin
      nl_row    = rows_last;
      nl_scroll = 1'b1;
    end else begin
      nl_row    = row_cap + ccur_pkg::TROW_W'(1);
      nl_scroll = 1'b0;
    end
  end

  // Tab: next multiple of 8, capped at the column count
  always_comb begin
    tab_col = (col_cap + ccur_pkg::COLS_W'(8)) & ~ccur_pkg::COLS_W'(7);
    if (tab_col > cols_eff) tab_col = cols_eff;
  end

  // Printable: wrap first when the row is full
  always_comb begin
    wrap     = (col_cap >= cols_eff);
    draw_col = wrap ? '0 : col_cap;
    draw_row = wrap ? nl_row : row_cap;
  end

  // Classify the character
  always_comb begin
    cursor_column_next = col_cap;
    cursor_row_next    = row_cap;
    job                = '0;
    case (chars.char_code)
      ccur_pkg::CH_RETURN: begin
        cursor_column_next = '0;
      end
      ccur_pkg::CH_NEWLINE: begin
        cursor_column_next = '0;
        cursor_row_next    = nl_row;
        job.has_scroll     = nl_scroll;
      end
      ccur_pkg::CH_TAB: begin
        cursor_column_next = tab_col;
      end
      ccur_pkg::CH_BACK: begin
        if (col_cap == '0) begin
          cursor_column_next = cols_eff - ccur_pkg::COLS_W'(1);
          if (row_cap != '0) cursor_row_next = row_cap - ccur_pkg::TROW_W'(1);
        end else begin
          cursor_column_next = col_cap - ccur_pkg::COLS_W'(1);
        end
        job.has_draw = 1'b1;
        job.glyph    = ccur_pkg::CH_SPACE;
        job.column   = cursor_column_next[ccur_pkg::TCOL_W-1:0];
        job.row      = cursor_row_next;
      end
      default: begin
        cursor_column_next = draw_col + ccur_pkg::COLS_W'(1);
        cursor_row_next    = draw_row;
        job.has_scroll     = wrap && nl_scroll;
        job.has_draw       = 1'b1;
        job.glyph          = chars.char_code;
        job.column         = draw_col[ccur_pkg::TCOL_W-1:0];
        job.row            = draw_row;
      end
    endcase
  end

  // Handshake: an item is taken whenever the queue has room
  assign chars.ready = job_ready;
  assign accept      = chars.valid && job_ready;
  assign job_valid   = chars.valid && (job.has_scroll || job.has_draw);

  // Cursor and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column  <= '0;
      cursor_row     <= '0;
      columns_in_use <= ccur_pkg::COLUMNS_RESET;
      rows_in_use    <= ccur_pkg::ROWS_RESET;
    end else begin
      if (accept) begin
        cursor_column <= cursor_column_next;
        cursor_row    <= cursor_row_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          ccur_pkg::REG_COLUMNS: columns_in_use <= cfg_data[ccur_pkg::COLS_W-1:0];
          ccur_pkg::REG_ROWS:    rows_in_use    <= cfg_data[ccur_pkg::ROWS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[hw/rtl/ccur_queue.sv]
// ----------------------------------------------------------------------------
// ccur_queue
// Short job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module ccur_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ccur_pkg::job_t   in_job,
  output logic             out_valid,
  input  logic             out_ready,
  output ccur_pkg::job_t   out_job
);

  ccur_pkg::job_t                entries [ccur_pkg::QUEUE_DEPTH];
  logic [ccur_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [ccur_pkg::QPTR_W:0]     fill;
  logic                          push, pop;

  assign in_ready  = (fill < (ccur_pkg::QPTR_W+1)'(ccur_pkg::QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_job   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_job;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + ccur_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + ccur_pkg::QPTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (ccur_pkg::QPTR_W+1)'(1);
        2'b01:   fill <= fill - (ccur_pkg::QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/ccur_back.sv]
// ----------------------------------------------------------------------------
// ccur_back
// Unpacks jobs into single registered requests, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ccur_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  ccur_pkg::job_t   job,
  ccur_req_if.source       reqs
);

  logic scroll_done;
  logic load, emit_scroll;

  // Output register free, or emptied this cycle
  assign load        = job_valid && (!reqs.valid || reqs.ready);
  assign emit_scroll = job.has_scroll && !scroll_done;
  assign job_ready   = load && !(emit_scroll && job.has_draw);

  // Control: output valid and the scroll-issued flag of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      reqs.valid  <= 1'b0;
      scroll_done <= 1'b0;
    end else begin
      if (load) begin
        reqs.valid  <= 1'b1;
        scroll_done <= emit_scroll && job.has_draw;
      end else if (reqs.ready) begin
        reqs.valid  <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_scroll) begin
        reqs.request_kind <= ccur_pkg::KIND_SCROLL;
        reqs.glyph_code   <= '0;
        reqs.text_column  <= '0;
        reqs.text_row     <= '0;
        reqs.last_of_run  <= !job.has_draw;
      end else begin
        reqs.request_kind <= ccur_pkg::KIND_DRAW;
        reqs.glyph_code   <= job.glyph;
        reqs.text_column  <= job.column;
        reqs.text_row     <= job.row;
        reqs.last_of_run  <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/text_console_cursor_engine.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text cursor control: characters in, draw and scroll requests out.
//
//   channel  dir  transfer                      payload
//   chars    in   valid & ready                 char_code
//   reqs     out  valid & ready                 request_kind, glyph_code,
//                                               text_column, text_row,
//                                               last_of_run
//   cfg      in   cfg_we (no handshake)         cfg_index, cfg_data
//
// A character is taken in the cycle it arrives while the job queue has room;
// the cursor updates as each is taken, so characters can stream back to back.
// The back end issues one request per cycle while the output is not stalled,
// so a character giving two requests (scroll then draw) sends them in turn.
// A character's first request passes a queue entry, then the output register.
// Synchronous reset clears cursor, queue and output; registers go to 15 x 8.
// Output stalls back up through the four-entry queue to chars.ready.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
  input  logic                              clk,
  input  logic                              rst,
  ccur_char_if.sink                         chars,
  ccur_req_if.source                        reqs,
  input  logic                              cfg_we,
  input  logic [ccur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccur_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic           fq_valid, fq_ready, qb_valid, qb_ready;
  ccur_pkg::job_t fq_job, qb_job;

  // Front: cursor and classification
  ccur_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // Job queue
  ccur_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  // Back: request sequencing
  ccur_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .reqs      (reqs)
  );

endmodule

[hw/rtl/ccur_checker.sv]
// ----------------------------------------------------------------------------
// ccur_checker
// Port-level checks on the request stream, bound to the top level.
// ----------------------------------------------------------------------------
module ccur_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_kind,
  input logic [ccur_pkg::CHAR_W-1:0]     out_glyph,
  input logic [ccur_pkg::TCOL_W-1:0]     out_column,
  input logic [ccur_pkg::TROW_W-1:0]     out_row,
  input logic                            out_last
);

  // Stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_glyph) && $stable(out_column) && $stable(out_row) &&
      $stable(out_last))
    else $error("request changed while stalled");

  // Scroll requests carry zero fields
  a_scroll_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == ccur_pkg::KIND_SCROLL |->
      out_glyph == '0 && out_column == '0 && out_row == '0)
    else $error("scroll request with non-zero fields");

  // Only a scroll can be followed by more requests of the same character
  a_not_last_scroll: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_kind == ccur_pkg::KIND_SCROLL)
    else $error("draw request not marked last");

  // A scroll that is not last is followed by a draw
  a_scroll_then_draw: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=>
      out_valid && out_kind == ccur_pkg::KIND_DRAW)
    else $error("missing draw after scroll");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind text_console_cursor_engine ccur_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (reqs.valid),
  .out_ready  (reqs.ready),
  .out_kind   (reqs.request_kind),
  .out_glyph  (reqs.glyph_code),
  .out_column (reqs.text_column),
  .out_row    (reqs.text_row),
  .out_last   (reqs.last_of_run)
);
